// ===== rtl/core/indexed_doubly_linked_list_top_assert.svh =====
// assertion macros for the linked list block
`ifndef INDEXED_DOUBLY_LINKED_LIST_TOP_ASSERT_SVH
`define INDEXED_DOUBLY_LINKED_LIST_TOP_ASSERT_SVH

`ifndef SYNTH
`define IDLL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("idll assertion failed");
`define IDLL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("idll assertion failed");
`else
`define IDLL_ASSERT(lbl, clk, rst_n, prop)
`define IDLL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/core/idll_pkg.sv =====
`default_nettype none

package idll_pkg;

    localparam int NODES_DEF       = 64;
    localparam int VALUE_RANGE_DEF = 256;
    localparam int UPC_W           = 4;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT    = 3'd0,
        ACT_INSERT_AFTER  = 3'd1,
        ACT_INSERT_BEFORE = 3'd2,
        ACT_ERASE         = 3'd3,
        ACT_FIND          = 3'd4,
        ACT_TRAVERSE      = 3'd5
    } act_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ADDR_ZERO = 2'd0,
        ADDR_POS  = 2'd1,
        ADDR_CUR  = 2'd2
    } addr_sel_t;

    typedef enum logic [1:0] {
        WR_NONE     = 2'd0,
        WR_INS_NEW  = 2'd1,
        WR_INS_LINK = 2'd2,
        WR_ERASE    = 2'd3
    } wr_op_t;

    typedef enum logic [2:0] {
        EM_NONE   = 3'd0,
        EM_STATUS = 3'd1,
        EM_INS    = 3'd2,
        EM_FIND   = 3'd3,
        EM_EMPTY  = 3'd4,
        EM_TRAV   = 3'd5
    } emit_t;

    typedef enum logic [1:0] {
        J_NEXT   = 2'd0,
        J_END    = 2'd1,
        J_CUR_NZ = 2'd2,
        J_MORE   = 2'd3
    } jump_t;

    typedef struct packed {
        addr_sel_t         addr_sel;
        wr_op_t            wr_op;
        logic              latch_lr;
        logic              load_cur;
        emit_t             emit;
        jump_t             jump;
        logic [UPC_W-1:0]  target;
    } ucode_t;

    typedef struct packed {
        ucode_t uc;
        logic   fire;
    } seq_ctrl_t;

    typedef struct packed {
        logic cur_nz;
        logic trav_last;
    } dp_flags_t;

    typedef struct packed {
        logic             valid;
        logic [UPC_W-1:0] entry;
    } dispatch_t;

    typedef struct packed {
        logic       last;
        logic       list_empty;
        logic [7:0] node_value;
        logic [5:0] node_index;
        status_t    status;
    } result_t;

    // program entry points
    localparam logic [UPC_W-1:0] UA_INS    = 4'd0;
    localparam logic [UPC_W-1:0] UA_ERASE  = 4'd3;
    localparam logic [UPC_W-1:0] UA_FIND   = 4'd5;
    localparam logic [UPC_W-1:0] UA_TRAV   = 4'd7;
    localparam logic [UPC_W-1:0] UA_WALK   = 4'd11;
    localparam logic [UPC_W-1:0] UA_STATUS = 4'd13;

    localparam ucode_t UC_NOP = '{
        addr_sel: ADDR_ZERO,
        wr_op:    WR_NONE,
        latch_lr: 1'b0,
        load_cur: 1'b0,
        emit:     EM_NONE,
        jump:     J_NEXT,
        target:   '0
    };

    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] pc);
        ucode_t uc;
        uc = UC_NOP;
        unique case (pc)
            4'd0: begin
                uc.addr_sel = ADDR_POS;
            end
            4'd1: begin
                uc.addr_sel = ADDR_POS;
                uc.wr_op    = WR_INS_NEW;
                uc.latch_lr = 1'b1;
            end
            4'd2: begin
                uc.wr_op = WR_INS_LINK;
                uc.emit  = EM_INS;
                uc.jump  = J_END;
            end
            4'd3: begin
                uc.addr_sel = ADDR_POS;
            end
            4'd4: begin
                uc.addr_sel = ADDR_POS;
                uc.wr_op    = WR_ERASE;
                uc.emit     = EM_STATUS;
                uc.jump     = J_END;
            end
            4'd5: begin
                uc.jump = J_NEXT;
            end
            4'd6: begin
                uc.emit = EM_FIND;
                uc.jump = J_END;
            end
            4'd7: begin
                uc.addr_sel = ADDR_ZERO;
            end
            4'd8: begin
                uc.load_cur = 1'b1;
            end
            4'd9: begin
                uc.jump   = J_CUR_NZ;
                uc.target = UA_WALK;
            end
            4'd10: begin
                uc.emit = EM_EMPTY;
                uc.jump = J_END;
            end
            4'd11: begin
                uc.addr_sel = ADDR_CUR;
            end
            4'd12: begin
                uc.addr_sel = ADDR_CUR;
                uc.emit     = EM_TRAV;
                uc.load_cur = 1'b1;
                uc.jump     = J_MORE;
                uc.target   = UA_WALK;
            end
            4'd13: begin
                uc.emit = EM_STATUS;
                uc.jump = J_END;
            end
            default: begin
                uc.jump = J_END;
            end
        endcase
        return uc;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/idll_ram.sv =====
`default_nettype none

module idll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/idll_seq.sv =====
`default_nettype none

module idll_seq (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [idll_pkg::UPC_W-1:0]   entry,
    input  wire idll_pkg::dp_flags_t          flags,
    input  wire logic                         out_free,
    output idll_pkg::seq_ctrl_t               ctrl,
    output logic                              busy
);

    logic [idll_pkg::UPC_W-1:0] pc_reg, pc_next;
    logic                       busy_reg, busy_next;
    idll_pkg::ucode_t           uc;
    logic                       fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= '0;
            busy_reg <= 1'b0;
        end else begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

    always_comb begin
        uc        = idll_pkg::ucode_rom(pc_reg);
        fire      = busy_reg && ((uc.emit == idll_pkg::EM_NONE) || out_free);
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (start) begin
            pc_next   = entry;
            busy_next = 1'b1;
        end else if (fire) begin
            unique case (uc.jump)
                idll_pkg::J_NEXT: begin
                    pc_next = pc_reg + 1'b1;
                end
                idll_pkg::J_END: begin
                    busy_next = 1'b0;
                end
                idll_pkg::J_CUR_NZ: begin
                    pc_next = flags.cur_nz ? uc.target : pc_reg + 1'b1;
                end
                idll_pkg::J_MORE: begin
                    if (flags.trav_last) begin
                        busy_next = 1'b0;
                    end else begin
                        pc_next = uc.target;
                    end
                end
            endcase
        end
    end

    assign ctrl.uc   = uc;
    assign ctrl.fire = fire;
    assign busy      = busy_reg;

endmodule

`default_nettype wire

// ===== rtl/core/idll_dp.sv =====
`default_nettype none

module idll_dp #(
    parameter int NODES       = idll_pkg::NODES_DEF,
    parameter int VALUE_RANGE = idll_pkg::VALUE_RANGE_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [2:0]            in_action,
    input  wire logic [5:0]            in_position,
    input  wire logic [7:0]            in_value,
    input  wire idll_pkg::seq_ctrl_t   ctrl,
    output logic                       ready,
    output idll_pkg::dispatch_t        disp,
    output idll_pkg::dp_flags_t        flags,
    output idll_pkg::result_t          res
);

    localparam int IDX_W = $clog2(NODES);
    localparam int MAP_W = $clog2(VALUE_RANGE);

    logic [IDX_W-1:0]    pos_reg, cur_reg, left_reg, right_reg, k_reg;
    logic [IDX_W-1:0]    count_reg, count_next;
    logic [7:0]          val_reg;
    logic                before_reg;
    idll_pkg::status_t   status_reg;
    logic                clr_busy_reg, clr_busy_next;
    logic [MAP_W-1:0]    clr_addr_reg, clr_addr_next;

    // dispatch
    idll_pkg::act_t      act;
    logic [IDX_W+5:0]    pos_wide, cnt_wide;
    logic                pos_above, full;
    idll_pkg::status_t   status_next;
    logic [IDX_W-1:0]    pos_next;
    logic                before_next;

    // memory ports
    logic                next_we, prev_we, val_we, map_we;
    logic [IDX_W-1:0]    next_waddr, prev_waddr, val_waddr, link_raddr;
    logic [IDX_W-1:0]    next_wdata, prev_wdata, map_wdata;
    logic [MAP_W-1:0]    map_waddr, map_raddr;
    logic [IDX_W-1:0]    next_rd, prev_rd, map_rd;
    logic [7:0]          val_rd;

    logic [MAP_W+7:0]    find_wide, erase_wide;
    logic                find_in_range, erase_in_range;
    logic [IDX_W-1:0]    left_sel, right_sel, n_idx;
    logic [IDX_W+5:0]    res_idx_wide;
    logic [IDX_W-1:0]    res_idx;
    idll_pkg::wr_op_t    wr;
    logic                trav_last;

    always_comb begin
        act         = idll_pkg::act_t'(in_action);
        pos_wide    = (IDX_W + 6)'(in_position);
        cnt_wide    = (IDX_W + 6)'(count_reg);
        pos_above   = pos_wide > cnt_wide;
        full        = count_reg >= IDX_W'(NODES - 1);
        disp.valid  = 1'b1;
        disp.entry  = idll_pkg::UA_STATUS;
        status_next = idll_pkg::ST_OK;
        pos_next    = pos_wide[IDX_W-1:0];
        before_next = 1'b0;
        unique case (act) inside
            idll_pkg::ACT_PUSH_FRONT, idll_pkg::ACT_INSERT_AFTER,
            idll_pkg::ACT_INSERT_BEFORE: begin
                if (act != idll_pkg::ACT_PUSH_FRONT && pos_above) begin
                    status_next = idll_pkg::ST_BAD;
                end else if (full) begin
                    status_next = idll_pkg::ST_FULL;
                end else begin
                    disp.entry = idll_pkg::UA_INS;
                end
                // push front is insert after the sentinel
                if (act == idll_pkg::ACT_PUSH_FRONT) begin
                    pos_next = '0;
                end
                before_next = (act == idll_pkg::ACT_INSERT_BEFORE);
            end
            idll_pkg::ACT_ERASE: begin
                if (in_position == 6'd0 || pos_above) begin
                    status_next = idll_pkg::ST_BAD;
                end else begin
                    disp.entry = idll_pkg::UA_ERASE;
                end
            end
            idll_pkg::ACT_FIND: begin
                disp.entry = idll_pkg::UA_FIND;
            end
            idll_pkg::ACT_TRAVERSE: begin
                disp.entry = idll_pkg::UA_TRAV;
            end
            default: begin
                disp.valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        find_wide      = (MAP_W + 8)'(val_reg);
        find_in_range  = find_wide < (MAP_W + 8)'(VALUE_RANGE);
        map_raddr      = find_wide[MAP_W-1:0];
        erase_wide     = (MAP_W + 8)'(val_rd);
        erase_in_range = erase_wide < (MAP_W + 8)'(VALUE_RANGE);
        left_sel       = before_reg ? prev_rd : pos_reg;
        right_sel      = before_reg ? pos_reg : next_rd;
        n_idx          = count_reg + 1'b1;
        trav_last      = (next_rd == '0) || (k_reg == IDX_W'(NODES - 2));
        unique case (ctrl.uc.addr_sel)
            idll_pkg::ADDR_POS: link_raddr = pos_reg;
            idll_pkg::ADDR_CUR: link_raddr = cur_reg;
            default:            link_raddr = '0;
        endcase
    end

    always_comb begin
        wr            = ctrl.fire ? ctrl.uc.wr_op : idll_pkg::WR_NONE;
        next_we       = 1'b0;
        prev_we       = 1'b0;
        val_we        = 1'b0;
        map_we        = 1'b0;
        next_waddr    = '0;
        prev_waddr    = '0;
        val_waddr     = n_idx;
        next_wdata    = '0;
        prev_wdata    = '0;
        map_waddr     = '0;
        map_wdata     = '0;
        count_next    = count_reg;
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            // clearing pass: value map, and sentinel links on the first cycle
            map_we        = 1'b1;
            map_waddr     = clr_addr_reg;
            next_we       = (clr_addr_reg == '0);
            prev_we       = (clr_addr_reg == '0);
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == MAP_W'(VALUE_RANGE - 1)) begin
                clr_busy_next = 1'b0;
            end
        end else begin
            unique case (wr)
                idll_pkg::WR_INS_NEW: begin
                    next_we    = 1'b1;
                    next_waddr = n_idx;
                    next_wdata = right_sel;
                    prev_we    = 1'b1;
                    prev_waddr = n_idx;
                    prev_wdata = left_sel;
                    val_we     = 1'b1;
                    map_we     = find_in_range;
                    map_waddr  = find_wide[MAP_W-1:0];
                    map_wdata  = n_idx;
                end
                idll_pkg::WR_INS_LINK: begin
                    next_we    = 1'b1;
                    next_waddr = left_reg;
                    next_wdata = n_idx;
                    prev_we    = 1'b1;
                    prev_waddr = right_reg;
                    prev_wdata = n_idx;
                    count_next = n_idx;
                end
                idll_pkg::WR_ERASE: begin
                    next_we    = 1'b1;
                    next_waddr = prev_rd;
                    next_wdata = next_rd;
                    prev_we    = 1'b1;
                    prev_waddr = next_rd;
                    prev_wdata = prev_rd;
                    map_we     = erase_in_range;
                    map_waddr  = erase_wide[MAP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            count_reg    <= count_next;
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            pos_reg    <= pos_next;
            val_reg    <= in_value;
            before_reg <= before_next;
            status_reg <= status_next;
            k_reg      <= '0;
        end else if (ctrl.fire && ctrl.uc.emit == idll_pkg::EM_TRAV) begin
            k_reg <= k_reg + 1'b1;
        end
        if (ctrl.fire && ctrl.uc.latch_lr) begin
            left_reg  <= left_sel;
            right_reg <= right_sel;
        end
        if (ctrl.fire && ctrl.uc.load_cur) begin
            cur_reg <= next_rd;
        end
    end

    idll_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_next_ram (
        .clk(aclk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(link_raddr), .rdata(next_rd)
    );

    idll_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_prev_ram (
        .clk(aclk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
        .raddr(link_raddr), .rdata(prev_rd)
    );

    idll_ram #(.WIDTH(8), .DEPTH(NODES)) u_val_ram (
        .clk(aclk), .we(val_we), .waddr(val_waddr), .wdata(val_reg),
        .raddr(link_raddr), .rdata(val_rd)
    );

    idll_ram #(.WIDTH(IDX_W), .DEPTH(VALUE_RANGE)) u_map_ram (
        .clk(aclk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rd)
    );

    always_comb begin
        res.status     = idll_pkg::ST_OK;
        res.node_value = 8'd0;
        res.list_empty = 1'b0;
        res.last       = 1'b1;
        res_idx        = '0;
        unique case (ctrl.uc.emit)
            idll_pkg::EM_STATUS: begin
                res.status = status_reg;
            end
            idll_pkg::EM_INS: begin
                res_idx = n_idx;
            end
            idll_pkg::EM_FIND: begin
                res_idx = find_in_range ? map_rd : '0;
            end
            idll_pkg::EM_EMPTY: begin
                res.list_empty = 1'b1;
            end
            idll_pkg::EM_TRAV: begin
                res_idx        = cur_reg;
                res.node_value = val_rd;
                res.last       = trav_last;
            end
            default: begin
            end
        endcase
        res_idx_wide   = (IDX_W + 6)'(res_idx);
        res.node_index = res_idx_wide[5:0];
    end

    assign ready           = !clr_busy_reg;
    assign flags.cur_nz    = (cur_reg != '0);
    assign flags.trav_last = trav_last;

endmodule

`default_nettype wire

// ===== rtl/core/indexed_doubly_linked_list_top.sv =====
// result of an accepted transaction goes to the output register: insert, erase, find and
// rejected actions give one result each, unused actions give no result
// traverse: one list_empty result on an empty list, else one result per node, tlast on the last
// no new transaction is accepted while the sequencer is still busy with the last one
// reset: synchronous active low; a clearing pass over all VALUE_RANGE entries zeroes the
// value map and sentinel links, input not accepted until it ends
`default_nettype none
`include "indexed_doubly_linked_list_top_assert.svh"

module indexed_doubly_linked_list_top #(
    parameter int NODES       = idll_pkg::NODES_DEF,
    parameter int VALUE_RANGE = idll_pkg::VALUE_RANGE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // action[2:0], position[8:3], value[16:9]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // status[1:0], node_index[7:2], node_value[15:8],
                                        // list_empty[16]
    output logic             m_tlast
);

    idll_pkg::seq_ctrl_t ctrl;
    idll_pkg::dp_flags_t flags;
    idll_pkg::dispatch_t disp;
    idll_pkg::result_t   res;
    idll_pkg::result_t   out_reg;
    logic                m_valid_reg, m_valid_next;
    logic                dp_ready, busy, start, out_free, out_load;
    logic                walk_more;

    assign s_tready = dp_ready && !busy;
    assign start    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign out_load = ctrl.fire && (ctrl.uc.emit != idll_pkg::EM_NONE);

    idll_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start && disp.valid),
        .entry    (disp.entry),
        .flags    (flags),
        .out_free (out_free),
        .ctrl     (ctrl),
        .busy     (busy)
    );

    idll_dp #(.NODES(NODES), .VALUE_RANGE(VALUE_RANGE)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .in_action   (s_tdata[2:0]),
        .in_position (s_tdata[8:3]),
        .in_value    (s_tdata[16:9]),
        .ctrl        (ctrl),
        .ready       (dp_ready),
        .disp        (disp),
        .flags       (flags),
        .res         (res)
    );

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_reg.list_empty, out_reg.node_value,
                       out_reg.node_index, out_reg.status};
    assign m_tlast  = out_reg.last;

    assign walk_more = ctrl.fire && (ctrl.uc.emit == idll_pkg::EM_TRAV) && !flags.trav_last;

    `IDLL_ASSERT(a_load_when_free, aclk, aresetn, out_load |-> out_free)
    `IDLL_ASSERT(a_valid_from_fire, aclk, aresetn, $rose(m_tvalid) |-> $past(out_load))
    `IDLL_ASSERT(a_walk_continues, aclk, aresetn, walk_more |=> busy)
    `IDLL_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid)

endmodule

`default_nettype wire

// ===== dv/indexed_doubly_linked_list_top_tb.sv =====
`timescale 1ns / 1ps

module indexed_doubly_linked_list_top_tb;

    localparam int LIST_NODES    = idll_pkg::NODES_DEF;
    localparam int VALUE_SPAN    = idll_pkg::VALUE_RANGE_DEF;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 20;
    localparam int ITEMS_PER_PHASE = 75;

    // action codes that the block ignores
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    class list_shadow;
        logic [7:0] node_val [LIST_NODES];
        logic [5:0] next_idx [LIST_NODES];
        logic [5:0] prev_idx [LIST_NODES];
        logic [5:0] value_node [VALUE_SPAN];
        int unsigned allocated;
        idll_pkg::result_t expected_results [$];
        int mismatches;

        function new();
            next_idx[0] = '0;
            prev_idx[0] = '0;
            foreach (value_node[i]) value_node[i] = '0;
            allocated = 0;
            mismatches = 0;
        endfunction

        function void push_result(idll_pkg::status_t st, logic [5:0] idx, logic [7:0] nv,
                                  logic empty, logic lst);
            idll_pkg::result_t r;
            r.status     = st;
            r.node_index = idx;
            r.node_value = nv;
            r.list_empty = empty;
            r.last       = lst;
            expected_results.push_back(r);
        endfunction

        function logic [5:0] link_node(logic [5:0] left, logic [5:0] right, logic [7:0] val);
            logic [5:0] n;
            allocated++;
            n = allocated[5:0];
            node_val[n] = val;
            value_node[val] = n;
            prev_idx[n] = left;
            next_idx[n] = right;
            prev_idx[right] = n;
            next_idx[left] = n;
            return n;
        endfunction

        function void note_action(logic [2:0] act, logic [5:0] pos, logic [7:0] val);
            logic [5:0] left;
            logic [5:0] right;
            logic [5:0] cur;
            logic [5:0] nx;
            int k;
            case (act)
                idll_pkg::ACT_PUSH_FRONT, idll_pkg::ACT_INSERT_AFTER,
                idll_pkg::ACT_INSERT_BEFORE: begin
                    if (act != idll_pkg::ACT_PUSH_FRONT && pos > allocated) begin
                        push_result(idll_pkg::ST_BAD, '0, '0, 1'b0, 1'b1);
                    end else if (allocated >= LIST_NODES - 1) begin
                        push_result(idll_pkg::ST_FULL, '0, '0, 1'b0, 1'b1);
                    end else begin
                        if (act == idll_pkg::ACT_PUSH_FRONT) begin
                            left  = '0;
                            right = next_idx[0];
                        end else if (act == idll_pkg::ACT_INSERT_AFTER) begin
                            left  = pos;
                            right = next_idx[pos];
                        end else begin
                            left  = prev_idx[pos];
                            right = pos;
                        end
                        push_result(idll_pkg::ST_OK, link_node(left, right, val), '0,
                                    1'b0, 1'b1);
                    end
                end
                idll_pkg::ACT_ERASE: begin
                    if (pos == 0 || pos > allocated) begin
                        push_result(idll_pkg::ST_BAD, '0, '0, 1'b0, 1'b1);
                    end else begin
                        // map entry cleared even if it names a newer node
                        value_node[node_val[pos]] = '0;
                        left  = prev_idx[pos];
                        right = next_idx[pos];
                        next_idx[left] = right;
                        prev_idx[right] = left;
                        push_result(idll_pkg::ST_OK, '0, '0, 1'b0, 1'b1);
                    end
                end
                idll_pkg::ACT_FIND: begin
                    push_result(idll_pkg::ST_OK, value_node[val], '0, 1'b0, 1'b1);
                end
                idll_pkg::ACT_TRAVERSE: begin
                    cur = next_idx[0];
                    if (cur == 0) begin
                        push_result(idll_pkg::ST_OK, '0, '0, 1'b1, 1'b1);
                    end else begin
                        k = 0;
                        while (cur != 0 && k < LIST_NODES - 1) begin
                            nx = next_idx[cur];
                            push_result(idll_pkg::ST_OK, cur, node_val[cur], 1'b0,
                                        (nx == 0) || (k == LIST_NODES - 2));
                            k++;
                            cur = nx;
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        task report(string field, logic [31:0] want, logic [31:0] got);
            mismatches++;
            $display("mismatch at %0t: %s expected %0h got %0h", $time, field, want, got);
        endtask

        task check_result(logic [23:0] data, logic lst);
            idll_pkg::result_t want;
            if (expected_results.size() == 0) begin
                report("unexpected transaction", '0, 32'(data));
                return;
            end
            want = expected_results.pop_front();
            if (data[1:0] !== want.status)
                report("status", 32'(want.status), 32'(data[1:0]));
            if (data[7:2] !== want.node_index)
                report("node_index", 32'(want.node_index), 32'(data[7:2]));
            if (data[15:8] !== want.node_value)
                report("node_value", 32'(want.node_value), 32'(data[15:8]));
            if (data[16] !== want.list_empty)
                report("list_empty", 32'(want.list_empty), 32'(data[16]));
            if (lst !== want.last)
                report("last", 32'(want.last), 32'(lst));
        endtask
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    list_shadow sb;
    logic [7:0] value_pool [16];
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    indexed_doubly_linked_list_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tlast);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("indexed_doubly_linked_list_top_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task send_item(logic [2:0] act, logic [5:0] pos, logic [7:0] val);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {7'b0, val, pos, act};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_action(act, pos, val);
    endtask

    task wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.expected_results.size() != 0);
    endtask

    task run_directed();
        send_item(idll_pkg::ACT_TRAVERSE, 6'd0, 8'd0);
        send_item(idll_pkg::ACT_FIND, 6'd0, 8'd0);
        send_item(idll_pkg::ACT_ERASE, 6'd0, 8'd0);
        send_item(idll_pkg::ACT_ERASE, 6'd1, 8'd0);
        send_item(idll_pkg::ACT_INSERT_AFTER, 6'd1, 8'd1);
        send_item(idll_pkg::ACT_INSERT_BEFORE, 6'd63, 8'hff);
        send_item(idll_pkg::ACT_PUSH_FRONT, 6'd63, 8'h00);
        send_item(idll_pkg::ACT_INSERT_AFTER, 6'd0, 8'hff);
        send_item(idll_pkg::ACT_INSERT_BEFORE, 6'd0, 8'haa);
        send_item(idll_pkg::ACT_INSERT_AFTER, 6'd1, 8'h55);
        send_item(idll_pkg::ACT_INSERT_BEFORE, 6'd2, 8'haa);
        send_item(idll_pkg::ACT_FIND, 6'd0, 8'haa);
        send_item(idll_pkg::ACT_TRAVERSE, 6'd63, 8'hff);
        // erase of the newer duplicate clears the shared map entry
        send_item(idll_pkg::ACT_ERASE, 6'd5, 8'd0);
        send_item(idll_pkg::ACT_FIND, 6'd0, 8'haa);
        // erased node keeps its stale links
        send_item(idll_pkg::ACT_ERASE, 6'd5, 8'd0);
        send_item(idll_pkg::ACT_INSERT_AFTER, 6'd5, 8'h12);
        send_item(idll_pkg::ACT_INSERT_BEFORE, 6'd5, 8'h34);
        send_item(idll_pkg::ACT_FIND, 6'd0, 8'hff);
        send_item(ACT_SPARE_LO, 6'd63, 8'hff);
        send_item(ACT_SPARE_HI, 6'd0, 8'h00);
        send_item(idll_pkg::ACT_TRAVERSE, 6'd0, 8'd0);
        send_item(idll_pkg::ACT_ERASE, 6'd3, 8'd0);
        send_item(idll_pkg::ACT_TRAVERSE, 6'd0, 8'd0);
    endtask

    task random_item();
        int r;
        int unsigned top;
        logic [2:0] act;
        logic [5:0] pos;
        logic [7:0] val;
        top = sb.allocated;
        val = ($urandom_range(1) == 0) ? value_pool[$urandom_range(15)]
                                       : 8'($urandom_range(255));
        pos = 6'($urandom_range(63));
        r = $urandom_range(99);
        if (r < 12) begin
            act = idll_pkg::ACT_PUSH_FRONT;
        end else if (r < 24) begin
            act = idll_pkg::ACT_INSERT_AFTER;
            pos = 6'($urandom_range(top));
        end else if (r < 34) begin
            act = idll_pkg::ACT_INSERT_BEFORE;
            pos = 6'($urandom_range(top));
        end else if (r < 46) begin
            act = idll_pkg::ACT_ERASE;
            pos = (top == 0) ? 6'd1 : 6'($urandom_range(top, 1));
        end else if (r < 64) begin
            act = idll_pkg::ACT_FIND;
        end else if (r < 76) begin
            act = idll_pkg::ACT_TRAVERSE;
        end else if (r < 88) begin
            act = 3'($urandom_range(7));
            val = 8'($urandom_range(255));
        end else begin
            // out-of-range positions, or the sentinel for erase
            act = 3'($urandom_range(idll_pkg::ACT_ERASE, idll_pkg::ACT_INSERT_AFTER));
            pos = (top >= LIST_NODES - 1) ? 6'd0 : 6'($urandom_range(63, top + 1));
        end
        send_item(act, pos, val);
    endtask

    initial begin
        sb = new();
        foreach (value_pool[i]) value_pool[i] = 8'($urandom_range(255));
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();
        wait_results_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 50;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 50;
                end
                default: begin
                    idle_pct  = 24;
                    stall_pct = 24;
                end
            endcase
            repeat (ITEMS_PER_PHASE) random_item();
            wait_results_drained();
        end

        // fill the store, then hit it while full
        while (sb.allocated < LIST_NODES - 1) begin
            send_item(idll_pkg::ACT_PUSH_FRONT, 6'($urandom_range(63)),
                      8'($urandom_range(255)));
        end
        send_item(idll_pkg::ACT_PUSH_FRONT, 6'd0, 8'h5a);
        send_item(idll_pkg::ACT_INSERT_AFTER, 6'd0, 8'ha5);
        send_item(idll_pkg::ACT_INSERT_BEFORE, 6'd63, 8'h3c);
        send_item(idll_pkg::ACT_TRAVERSE, 6'd0, 8'd0);
        send_item(idll_pkg::ACT_FIND, 6'd0, 8'h5a);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("indexed_doubly_linked_list_top_tb: PASS");
        end else begin
            $display("indexed_doubly_linked_list_top_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/idll_pkg.sv
rtl/core/idll_ram.sv
rtl/core/idll_seq.sv
rtl/core/idll_dp.sv
rtl/core/indexed_doubly_linked_list_top.sv
dv/indexed_doubly_linked_list_top_tb.sv
